// ===== design/msc_pkg.sv =====
// shared types and codes for the mesi snoop cache controller
// no dependencies
`timescale 1ns / 1ps

package msc_pkg;

  typedef enum logic [1:0] {
    ST_I = 2'd0,
    ST_S = 2'd1,
    ST_E = 2'd2,
    ST_M = 2'd3
  } mesi_e;

  typedef enum logic [1:0] {
    OUT_STALL   = 2'd0,
    OUT_HIT     = 2'd1,
    OUT_REFUSED = 2'd2,
    OUT_ISSUED  = 2'd3
  } outcome_e;

  localparam logic [1:0] REG_SET_BITS   = 2'd0;
  localparam logic [1:0] REG_BLOCK_BITS = 2'd1;
  localparam logic [1:0] REG_WAYS       = 2'd2;

  localparam logic [3:0] BLOCK_BITS_MAX = 4'd12;
  localparam logic [47:0] CYC_MAX = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic        valid;
    mesi_e       mesi;
    logic [31:0] tag;
    logic [31:0] lru;
  } line_t;

  typedef struct packed {
    logic [3:0] set_bits;
    logic [3:0] block_bits;
    logic [4:0] ways;
  } cfg_t;

  typedef struct packed {
    logic [47:0] ready_cycle;
    logic [11:0] transfer_cycles;
    logic [3:0]  victim_way;
    logic        did_evict;
    logic        did_writeback;
    logic        supplied_by_cache;
    logic [1:0]  copies_invalidated;
    mesi_e       line_state;
    outcome_e    outcome;
  } result_t;

endpackage

// ===== design/mesi_snoop_cache_controller_core.sv =====
// mesi snoop cache controller: sequencer around the shared line store
// depends on msc_pkg, msc_line_ram, msc_apb_regs
//
// channel   dir  handshake                  payload
// s_axis    in   tvalid/tready              core, address, cycle; tuser is_write
// m_axis    out  tvalid/tready              one result beat per access
// apb       in   psel/penable, pready=1     set bits, block bits, ways
//
// after its accept, an access runs the fill check over the cores, with a
// fill write for each due fill, then, for a core that is not stalled, the
// way scan over the set row and the decision, before its result beat
// after reset a clearing pass writes MAX_SETS rows, one a cycle, before
// the first beat is taken; a held result blocks the next beat
`timescale 1ns / 1ps

module mesi_snoop_cache_controller_core
  import msc_pkg::*;
#(
  parameter int CORES       = 4,
  parameter int MAX_SETS    = 1024,
  parameter int MAX_WAYS    = 16,
  parameter int MEM_LATENCY = 100
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // core_id[1:0], address[33:2], cycle_now[81:34], zero fill
  input  logic [87:0] s_axis_tdata,
  // is_write[0]
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // outcome[1:0], line_state[3:2], copies_invalidated[5:4],
  // supplied_by_cache[6], did_writeback[7], did_evict[8], victim_way[12:9],
  // transfer_cycles[24:13], ready_cycle[72:25], zero fill
  output logic [79:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CW   = $clog2(CORES);
  localparam int SW   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int WW   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int SMAX = $clog2(MAX_SETS + 1) - 1;

  typedef enum logic [7:0] {
    S_CLR  = 8'b0000_0001,
    S_IDLE = 8'b0000_0010,
    S_FILL = 8'b0000_0100,
    S_FLD  = 8'b0000_1000,
    S_ACC  = 8'b0001_0000,
    S_SCAN = 8'b0010_0000,
    S_DEC  = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  cfg_t   cfg;

  msc_apb_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  logic                            rd_en, wr_en;
  logic [SW-1:0]                   rd_addr, wr_addr;
  line_t [CORES-1:0][MAX_WAYS-1:0] wdata, rdata;

  msc_line_ram #(
    .CORES   (CORES),
    .MAX_SETS(MAX_SETS),
    .MAX_WAYS(MAX_WAYS),
    .SW      (SW)
  ) u_ram (
    .clk_i    (clk_i),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wdata_i  (wdata),
    .rdata_o  (rdata)
  );

  // access latched at accept
  logic [1:0]    core_q;
  logic          wr_q;
  logic [SW-1:0] set_q;
  logic [31:0]   tag_q;
  logic [47:0]   now_q;
  logic [3:0]    b_q;

  // per core state
  logic [31:0]   use_cnt_q [CORES];
  logic [47:0]   resume_q  [CORES];
  logic          pend_q    [CORES];
  logic [SW-1:0] fset_q    [CORES];
  logic [WW-1:0] fway_q    [CORES];
  logic [31:0]   ftag_q    [CORES];
  mesi_e         fmesi_q   [CORES];
  logic [47:0]   fdue_q    [CORES];
  logic [47:0]   bus_free_q;

  // scan state
  logic [CW-1:0] fc_q;
  logic [SW-1:0] clr_q;
  logic [WW-1:0] w_q;
  logic          found_q [CORES];
  logic [WW-1:0] mway_q  [CORES];
  mesi_e         mmesi_q [CORES];
  logic          vdone_q;
  logic [WW-1:0] vbest_q;
  logic [32:0]   least_q;

  result_t res_q, res_d;

  // address split from the live configuration
  logic [3:0]  b_eff, s_eff;
  logic [31:0] set_full, tag_in;
  logic [5:0]  ways_eff, last_way;
  always_comb begin
    b_eff    = (cfg.block_bits > BLOCK_BITS_MAX) ? BLOCK_BITS_MAX : cfg.block_bits;
    s_eff    = (32'(cfg.set_bits) > SMAX) ? 4'(SMAX) : cfg.set_bits;
    set_full = (s_axis_tdata[33:2] >> b_eff) & ((32'd1 << s_eff) - 32'd1);
    tag_in   = s_axis_tdata[33:2] >> (5'(s_eff) + 5'(b_eff));
    if (cfg.ways == 5'd0) begin
      ways_eff = 6'd1;
    end else if (32'(cfg.ways) > MAX_WAYS) begin
      ways_eff = 6'(MAX_WAYS);
    end else begin
      ways_eff = 6'(cfg.ways);
    end
    last_way = ways_eff - 6'd1;
  end

  logic [CW-1:0] ci;
  logic          core_ok, fill_due;
  assign ci       = CW'(core_q);
  assign core_ok  = 32'(core_q) < CORES;
  assign fill_due = pend_q[fc_q] && (now_q >= fdue_q[fc_q]);

  // decision over the scanned row
  logic        hit, refused, shared, ev, wb;
  mesi_e       newst;
  logic [3:0]  inval;
  logic [12:0] fill_cyc, total;
  logic [48:0] sum_bf, sum_hit;
  logic [47:0] bf_sat, hit_sat;
  line_t [CORES-1:0][MAX_WAYS-1:0] row_mod;
  always_comb begin
    hit     = found_q[ci] && (mmesi_q[ci] != ST_I);
    refused = !hit && (now_q < bus_free_q);
    shared  = 1'b0;
    for (int o = 0; o < CORES; o++) begin
      if (o != 32'(ci) && found_q[o] && mmesi_q[o] != ST_I) shared = 1'b1;
    end
    row_mod = rdata;
    inval   = 4'd0;
    if (hit) begin
      for (int o = 0; o < CORES; o++) begin
        if (wr_q && mmesi_q[ci] == ST_S && o != 32'(ci) && found_q[o] &&
            mmesi_q[o] != ST_I) begin
          row_mod[o][mway_q[o]].mesi = ST_I;
          inval = inval + 4'd1;
        end
      end
      if (wr_q) row_mod[ci][mway_q[ci]].mesi = ST_M;
      row_mod[ci][mway_q[ci]].lru = use_cnt_q[ci];
    end else if (!refused) begin
      for (int o = 0; o < CORES; o++) begin
        if (o != 32'(ci) && found_q[o]) begin
          if (wr_q) begin
            if (mmesi_q[o] != ST_I) begin
              row_mod[o][mway_q[o]].mesi = ST_I;
              inval = inval + 4'd1;
            end
          end else if (mmesi_q[o] == ST_M || mmesi_q[o] == ST_E) begin
            row_mod[o][mway_q[o]].mesi = ST_S;
          end
        end
      end
    end
    newst = wr_q ? ST_M : (shared ? ST_S : ST_E);
    ev    = rdata[ci][vbest_q].valid;
    wb    = ev && (rdata[ci][vbest_q].mesi == ST_M);
    if (shared) begin
      fill_cyc = (b_q >= 4'd2) ? (13'd1 << (b_q - 4'd1)) : 13'd0;
    end else begin
      fill_cyc = 13'(MEM_LATENCY);
    end
    total   = fill_cyc + (wb ? 13'(MEM_LATENCY) : 13'd0);
    sum_bf  = {1'b0, now_q} + 49'(total);
    bf_sat  = sum_bf[48] ? CYC_MAX : sum_bf[47:0];
    sum_hit = {1'b0, now_q} + 49'd1;
    hit_sat = sum_hit[48] ? CYC_MAX : sum_hit[47:0];
  end

  logic [31:0] vic32;
  assign vic32 = 32'(vbest_q);

  always_comb begin
    res_d = '0;
    if (state_q == S_ACC) begin
      res_d.ready_cycle = core_ok ? resume_q[ci] : now_q;
    end else if (hit) begin
      res_d.outcome            = OUT_HIT;
      res_d.line_state         = wr_q ? ST_M : mmesi_q[ci];
      res_d.copies_invalidated = (inval > 4'd3) ? 2'd3 : inval[1:0];
      res_d.ready_cycle        = hit_sat;
    end else if (refused) begin
      res_d.outcome     = OUT_REFUSED;
      res_d.ready_cycle = bus_free_q;
    end else begin
      res_d.outcome            = OUT_ISSUED;
      res_d.line_state         = newst;
      res_d.copies_invalidated = (inval > 4'd3) ? 2'd3 : inval[1:0];
      res_d.supplied_by_cache  = shared;
      res_d.did_writeback      = wb;
      res_d.did_evict          = ev;
      res_d.victim_way         = vic32[3:0];
      res_d.transfer_cycles    = total[11:0];
      res_d.ready_cycle        = bf_sat;
    end
  end

  // memory port and next state
  always_comb begin
    state_d = state_q;
    rd_en   = 1'b0;
    rd_addr = set_q;
    wr_en   = 1'b0;
    wr_addr = set_q;
    wdata   = row_mod;
    unique case (state_q)
      S_CLR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        wdata   = '0;
        if (32'(clr_q) == MAX_SETS - 1) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (s_axis_tvalid) state_d = S_FILL;
      end
      S_FILL: begin
        if (fill_due) begin
          rd_en   = 1'b1;
          rd_addr = fset_q[fc_q];
          state_d = S_FLD;
        end else if (32'(fc_q) == CORES - 1) begin
          state_d = S_ACC;
        end
      end
      S_FLD: begin
        wr_en   = 1'b1;
        wr_addr = fset_q[fc_q];
        wdata   = rdata;
        wdata[fc_q][fway_q[fc_q]] = '{valid: 1'b1, mesi: fmesi_q[fc_q],
                                      tag: ftag_q[fc_q], lru: use_cnt_q[fc_q]};
        state_d = (32'(fc_q) == CORES - 1) ? S_ACC : S_FILL;
      end
      S_ACC: begin
        if (!core_ok || now_q < resume_q[ci]) begin
          state_d = S_OUT;
        end else begin
          rd_en   = 1'b1;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (6'(w_q) == last_way) state_d = S_DEC;
      end
      S_DEC: begin
        wr_en   = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (m_axis_tready) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLR;
      clr_q      <= '0;
      fc_q       <= '0;
      bus_free_q <= '0;
      for (int c = 0; c < CORES; c++) begin
        use_cnt_q[c] <= '0;
        resume_q[c]  <= '0;
        pend_q[c]    <= 1'b0;
      end
    end else begin
      state_q <= state_d;
      if (state_q == S_CLR) clr_q <= clr_q + SW'(1);
      if (state_q == S_IDLE) fc_q <= '0;
      if (state_q == S_FILL && !fill_due) fc_q <= fc_q + CW'(1);
      if (state_q == S_FLD) begin
        use_cnt_q[fc_q] <= use_cnt_q[fc_q] + 32'd1;
        pend_q[fc_q]    <= 1'b0;
        fc_q            <= fc_q + CW'(1);
      end
      if (state_q == S_DEC) begin
        if (hit) begin
          use_cnt_q[ci] <= use_cnt_q[ci] + 32'd1;
        end else if (!refused) begin
          bus_free_q   <= bf_sat;
          resume_q[ci] <= bf_sat;
          pend_q[ci]   <= 1'b1;
        end
      end
    end
  end

  // payload and scan registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE) begin
      core_q <= s_axis_tdata[1:0];
      wr_q   <= s_axis_tuser;
      now_q  <= s_axis_tdata[81:34];
      set_q  <= set_full[SW-1:0];
      tag_q  <= tag_in;
      b_q    <= b_eff;
    end
    if (state_q == S_ACC) begin
      w_q     <= '0;
      vdone_q <= 1'b0;
      vbest_q <= '0;
      least_q <= '1;
      for (int c = 0; c < CORES; c++) found_q[c] <= 1'b0;
    end
    if (state_q == S_SCAN) begin
      w_q <= w_q + WW'(1);
      for (int c = 0; c < CORES; c++) begin
        if (!found_q[c] && rdata[c][w_q].valid && rdata[c][w_q].tag == tag_q) begin
          found_q[c] <= 1'b1;
          mway_q[c]  <= w_q;
          mmesi_q[c] <= rdata[c][w_q].mesi;
        end
      end
      // victim: first invalid way, else first least recently used
      if (!vdone_q) begin
        if (!rdata[ci][w_q].valid) begin
          vdone_q <= 1'b1;
          vbest_q <= w_q;
        end else if ({1'b0, rdata[ci][w_q].lru} < least_q) begin
          least_q <= {1'b0, rdata[ci][w_q].lru};
          vbest_q <= w_q;
        end
      end
    end
    if (state_q == S_DEC && !hit && !refused) begin
      fset_q[ci]  <= set_q;
      fway_q[ci]  <= vbest_q;
      ftag_q[ci]  <= tag_q;
      fmesi_q[ci] <= newst;
      fdue_q[ci]  <= bf_sat;
    end
    if (state_q == S_ACC || state_q == S_DEC) res_q <= res_d;
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tdata  = {7'd0, res_q};

endmodule

// ===== design/msc_line_ram.sv =====
// line store: one row per set holding every core's ways, registered read
// depends on msc_pkg
`timescale 1ns / 1ps

module msc_line_ram
  import msc_pkg::*;
#(
  parameter int CORES    = 4,
  parameter int MAX_SETS = 1024,
  parameter int MAX_WAYS = 16,
  parameter int SW       = 10
) (
  input  logic                                  clk_i,
  input  logic                                  rd_en_i,
  input  logic [SW-1:0]                         rd_addr_i,
  input  logic                                  wr_en_i,
  input  logic [SW-1:0]                         wr_addr_i,
  input  line_t [CORES-1:0][MAX_WAYS-1:0]       wdata_i,
  output line_t [CORES-1:0][MAX_WAYS-1:0]       rdata_o
);

  line_t [CORES-1:0][MAX_WAYS-1:0] mem [MAX_SETS];
  line_t [CORES-1:0][MAX_WAYS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rdata_q <= mem[rd_addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/msc_apb_regs.sv =====
// configuration registers behind the apb port
// depends on msc_pkg
`timescale 1ns / 1ps

module msc_apb_regs
  import msc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (paddr[3:2])
        REG_SET_BITS:   cfg_d.set_bits   = pwdata[3:0];
        REG_BLOCK_BITS: cfg_d.block_bits = pwdata[3:0];
        REG_WAYS:       cfg_d.ways       = pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_SET_BITS:   prdata = {28'd0, cfg_q.set_bits};
      REG_BLOCK_BITS: prdata = {28'd0, cfg_q.block_bits};
      REG_WAYS:       prdata = {27'd0, cfg_q.ways};
      default:        prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.set_bits   <= 4'd6;
      cfg_q.block_bits <= 4'd5;
      cfg_q.ways       <= 5'd2;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
